>>> rtl/qdsf_pkg.sv
// ----------------------------------------------------------------------------
// qdsf_pkg
// Shared types and constants for the quadrature decoder with speed filter.
// ----------------------------------------------------------------------------
`default_nettype none

package qdsf_pkg;

   localparam int DELTA_W   = 16;
   localparam int POS_W     = 32;
   localparam int SPEED_W   = 24;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 88;

   localparam logic [1:0] CMD_PIN  = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_LOAD = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV
   } qdsf_state_type;

   typedef enum logic [1:0] {
      STEP_DEC,
      STEP_INC,
      STEP_ERR
   } qdsf_step_type;

   // code = previous pins * 4 + new pins, pins = {A, B}
   function automatic qdsf_step_type qdsf_step(input logic [3:0] code);
      qdsf_step_type r;
      case (code) inside
         4'b0001, 4'b0111, 4'b1110, 4'b1000: r = STEP_DEC;
         4'b0010, 4'b1011, 4'b1101, 4'b0100: r = STEP_INC;
         default:                            r = STEP_ERR;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/qdsf_window.sv
// ----------------------------------------------------------------------------
// qdsf_window
// Delta ring store with a serial weighted-sum walk, newest entry first.
// ----------------------------------------------------------------------------
`default_nettype none

module qdsf_window
   import qdsf_pkg::*;
#(
   parameter int WINDOW = 8,
   parameter int SUM_W  = 23
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DELTA_W-1:0]   push_delta,
   output logic                      sum_done,
   output logic [SUM_W-1:0]          sum
);

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);

   logic [DELTA_W-1:0] mem [WINDOW];
   logic [WINDOW-1:0]  vld_ff;

   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               data_vld_ff, data_vld_in;
   logic               done_ff, done_in;
   logic [DELTA_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic [SUM_W-1:0]   run_ff, run_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [DELTA_W-1:0] entry;

   assign entry = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      wp_in       = wp_ff;
      rd_addr_in  = rd_addr_ff;
      cnt_in      = cnt_ff;
      run_in      = run_ff;
      acc_in      = acc_ff;
      data_vld_in = (cnt_ff != '0);
      done_in     = data_vld_ff && (cnt_ff == '0);
      if (cnt_ff != '0) begin
         cnt_in     = cnt_ff - CNT_W'(1);
         rd_addr_in = (rd_addr_ff == '0) ? PTR_W'(WINDOW - 1) : rd_addr_ff - PTR_W'(1);
      end
      if (data_vld_ff) begin
         run_in = run_ff + {{(SUM_W-DELTA_W){entry[DELTA_W-1]}}, entry};
         acc_in = acc_ff + run_in;
      end
      if (push) begin
         wp_in      = (wp_ff == PTR_W'(WINDOW - 1)) ? '0 : wp_ff + PTR_W'(1);
         rd_addr_in = wp_ff;
         cnt_in     = CNT_W'(WINDOW);
         run_in     = '0;
         acc_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wp_ff] <= push_delta;
      end
      rd_data_ff <= mem[rd_addr_ff];
      rd_vld_ff  <= vld_ff[rd_addr_ff];
      run_ff     <= run_in;
      acc_ff     <= acc_in;
      rd_addr_ff <= rd_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         wp_ff       <= '0;
         cnt_ff      <= '0;
         data_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         if (push) begin
            vld_ff[wp_ff] <= 1'b1;
         end
         wp_ff       <= wp_in;
         cnt_ff      <= cnt_in;
         data_vld_ff <= data_vld_in;
         done_ff     <= done_in;
      end
   end

   assign sum_done = done_ff;
   assign sum      = acc_ff;

endmodule

`default_nettype wire

>>> rtl/qdsf_divider.sv
// ----------------------------------------------------------------------------
// qdsf_divider
// Bit-serial restoring divider by a constant, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qdsf_divider #(
   parameter int DIV_W   = 31,
   parameter int DIVISOR = 36
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient
);

   localparam int TOT_W = $clog2(DIVISOR + 1);
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] q_ff, q_in;
   logic [TOT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [TOT_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, q_ff[DIV_W-1]};
   assign fits  = (trial >= (TOT_W+1)'(DIVISOR));

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == CNT_W'(1));
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         q_in   = {q_ff[DIV_W-2:0], fits};
         rem_in = fits ? TOT_W'(trial - (TOT_W+1)'(DIVISOR)) : TOT_W'(trial);
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

>>> rtl/quadrature_decoder_speed_filter.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_filter
// Quadrature decoder with position count, error count and filtered speed.
// Each request beat carries a command in tuser: pin change, speed tick or
// position load, and yields one response beat with position, error count and
// speed (Q15.8). Pin change, load and unused commands finish in the accept
// cycle. A tick walks the delta window one entry per cycle through the
// window RAM read port and then runs a bit-serial divide by the weight total
// one quotient bit per cycle. No further request is taken until the response
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_speed_filter
   import qdsf_pkg::*;
#(
   parameter int WINDOW = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // pin_a, pin_b, load_value[31:0], pad
   input  wire logic [1:0]            req_tuser,  // cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata   // position, error_count, speed
);

   localparam int TOTAL = WINDOW * (WINDOW + 1) / 2;
   localparam int SUM_W = DELTA_W + $clog2(TOTAL + 1) + 1;
   localparam int DIV_W = SUM_W + 8;

   qdsf_state_type state_ff, state_in;

   logic [1:0]         prev_pins_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   err_ff;
   logic [POS_W-1:0]   last_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               neg_ff;

   logic               accept;
   logic               push;
   logic               div_start;
   logic [1:0]         cmd;
   logic [1:0]         pins_now;
   qdsf_step_type      step;
   logic [POS_W-1:0]   diff;
   logic [DELTA_W-1:0] delta;
   logic               walk_done;
   logic [SUM_W-1:0]   wsum;
   logic [SUM_W-1:0]   wmag;
   logic               div_done;
   logic [DIV_W-1:0]   quo;
   logic [SPEED_W:0]   avg;
   logic [SPEED_W:0]   tot;
   logic [SPEED_W:0]   tot_adj;

   assign cmd      = req_tuser;
   assign accept   = req_tvalid && req_tready;
   assign pins_now = {req_tdata[0], req_tdata[1]};
   assign step     = qdsf_step({prev_pins_ff, pins_now});

   assign diff  = pos_ff - last_ff;
   always_comb begin
      if (!diff[POS_W-1] && (diff[POS_W-2:DELTA_W-1] != '0)) begin
         delta = {1'b0, {(DELTA_W-1){1'b1}}};
      end else if (diff[POS_W-1] && (diff[POS_W-2:DELTA_W-1] != '1)) begin
         delta = {1'b1, {(DELTA_W-1){1'b0}}};
      end else begin
         delta = diff[DELTA_W-1:0];
      end
   end

   assign wmag = wsum[SUM_W-1] ? (~wsum + SUM_W'(1)) : wsum;

   assign avg     = neg_ff ? (~{1'b0, quo[SPEED_W-1:0]} + (SPEED_W+1)'(1))
                           : {1'b0, quo[SPEED_W-1:0]};
   assign tot     = avg + {speed_ff[SPEED_W-1], speed_ff};
   assign tot_adj = tot + {{SPEED_W{1'b0}}, tot[SPEED_W]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == CMD_TICK)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      push       = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_vld_ff || rsp_tready;
            push       = accept && (cmd == CMD_TICK);
         end
         ST_WALK: div_start = walk_done;
         ST_DIV:  ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if ((accept && (cmd != CMD_TICK)) || (state_ff == ST_DIV && div_done)) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         neg_ff <= wsum[SUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_vld_ff   <= 1'b0;
         prev_pins_ff <= '0;
         pos_ff       <= '0;
         err_ff       <= '0;
         last_ff      <= '0;
         speed_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (accept) begin
            case (cmd)
               CMD_PIN: begin
                  prev_pins_ff <= pins_now;
                  case (step)
                     STEP_DEC: pos_ff <= pos_ff - POS_W'(1);
                     STEP_INC: pos_ff <= pos_ff + POS_W'(1);
                     default:  err_ff <= err_ff + POS_W'(1);
                  endcase
               end
               CMD_TICK: last_ff <= pos_ff;
               CMD_LOAD: pos_ff  <= req_tdata[POS_W+1:2];
               default: ;
            endcase
         end
         if (state_ff == ST_DIV && div_done) begin
            speed_ff <= tot_adj[SPEED_W:1];
         end
      end
   end

   qdsf_window #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_delta (delta),
      .sum_done   (walk_done),
      .sum        (wsum)
   );

   qdsf_divider #(
      .DIV_W   (DIV_W),
      .DIVISOR (TOTAL)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({wmag, 8'b0}),
      .done     (div_done),
      .quotient (quo)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {speed_ff, err_ff, pos_ff};

   a_walk_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_done |-> state_ff == ST_WALK)
      else $error("window sum finished outside walk");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide");

   a_tick_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_TICK) |=> !rsp_tvalid && state_ff == ST_WALK)
      else $error("tick beat produced an early response");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept)
      else $error("request accepted while a tick is in progress");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrature decoder with speed filter. A queue
// of directed and random request beats (Gray-code step runs, bad steps, ticks,
// loads, unused commands) feeds a clocked driver. Each beat is predicted as it
// is put on the bus. A clocked monitor checks every response beat against the
// oldest prediction. Both sides stall at random until the last third of beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import qdsf_pkg::*;

   localparam logic [1:0] CMD_NONE     = 2'd3;
   localparam int         WINDOW       = 8;
   localparam longint     WEIGHT_TOTAL = WINDOW * (WINDOW + 1) / 2;
   localparam int         RANDOM_BEATS = 1600;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         DRAIN_CYCLES = 60;

   typedef struct {
      logic [1:0]         cmd;
      logic               pin_a;
      logic               pin_b;
      logic signed [31:0] load_value;
   } enc_beat_type;

   typedef struct {
      logic signed [31:0] position;
      logic [31:0]        error_count;
      logic signed [23:0] speed;
   } enc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // pin_a, pin_b, load_value[31:0], pad
   logic [1:0]            req_tuser  = '0;  // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // position, error_count, speed

   enc_beat_type   pending_q[$];
   enc_result_type expected_q[$];

   int total_beats    = 0;
   int beats_driven   = 0;
   int beats_received = 0;
   int failures       = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 37;
   int recv_idle_pct  = 70;

   // tracked decoder state
   logic [1:0]         trk_pins     = '0;
   logic [31:0]        trk_pos      = '0;
   logic [31:0]        trk_errs     = '0;
   logic [31:0]        trk_pos_tick = '0;
   logic signed [15:0] trk_window [WINDOW] = '{default: '0};
   logic [2:0]         trk_wptr     = '0;
   logic signed [23:0] trk_speed    = '0;

   enc_beat_type   drive_beat;
   enc_result_type got;
   enc_result_type want;

   quadrature_decoder_speed_filter #(
      .WINDOW(WINDOW)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic enc_result_type predict_decoder(input enc_beat_type beat);
      logic [1:0]         now;
      logic [3:0]         code;
      logic signed [31:0] d32;
      longint             delta;
      longint             acc;
      longint             avg;
      longint             spd;
      logic [2:0]         idx;
      enc_result_type     r;
      case (beat.cmd)
         CMD_PIN: begin
            now  = {beat.pin_a, beat.pin_b};
            code = {trk_pins, now};
            case (code)
               4'b0001, 4'b0111, 4'b1110, 4'b1000: trk_pos  = trk_pos - 32'd1;
               4'b0010, 4'b1011, 4'b1101, 4'b0100: trk_pos  = trk_pos + 32'd1;
               default:                            trk_errs = trk_errs + 32'd1;
            endcase
            trk_pins = now;
         end
         CMD_TICK: begin
            d32   = trk_pos - trk_pos_tick;
            delta = d32;
            if (delta > 32767)  delta = 32767;
            if (delta < -32768) delta = -32768;
            trk_window[trk_wptr] = delta[15:0];
            trk_wptr = trk_wptr + 3'd1;
            acc = 0;
            for (int i = 0; i < WINDOW; i++) begin
               idx = trk_wptr + 3'(i);
               acc = acc + longint'(i + 1) * longint'(trk_window[idx]);
            end
            avg = (acc * 256) / WEIGHT_TOTAL;
            spd = (avg + longint'(trk_speed)) / 2;
            trk_speed    = spd[23:0];
            trk_pos_tick = trk_pos;
         end
         CMD_LOAD: trk_pos = beat.load_value;
         default: ;
      endcase
      r.position    = trk_pos;
      r.error_count = trk_errs;
      r.speed       = trk_speed;
      return r;
   endfunction

   task automatic push_beat(input logic [1:0] cmd, input logic a, input logic b,
                            input logic [31:0] val);
      enc_beat_type t;
      t.cmd        = cmd;
      t.pin_a      = a;
      t.pin_b      = b;
      t.load_value = val;
      pending_q.push_back(t);
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (beats_driven < total_beats / 3) begin
            send_idle_pct <= 37;
            recv_idle_pct <= 70;
         end else if (beats_driven < 2 * total_beats / 3) begin
            send_idle_pct <= 70;
            recv_idle_pct <= 37;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         if (req_tvalid && !req_tready) begin
            // hold the current beat
         end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_beat = pending_q.pop_front();
            req_tdata  <= {6'b0, drive_beat.load_value, drive_beat.pin_b, drive_beat.pin_a};
            req_tuser  <= drive_beat.cmd;
            req_tvalid <= 1'b1;
            expected_q.push_back(predict_decoder(drive_beat));
            beats_driven++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            beats_received++;
            got.position    = rsp_tdata[31:0];
            got.error_count = rsp_tdata[63:32];
            got.speed       = rsp_tdata[87:64];
            if (expected_q.size() == 0) begin
               $error("response beat with no prediction pending");
               failures++;
            end else begin
               want = expected_q.pop_front();
               if (got.position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position, got.position);
                  failures++;
               end
               if (got.error_count !== want.error_count) begin
                  $error("error_count: expected %0d, actual %0d",
                         want.error_count, got.error_count);
                  failures++;
               end
               if (got.speed !== want.speed) begin
                  $error("speed: expected %0d, actual %0d", want.speed, got.speed);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      logic [1:0]  gen_pins;
      logic [1:0]  nxt;
      logic [31:0] val;
      bit          up;
      int          pick;

      // directed: first edge vs zero state, full cycles both ways, bad steps
      push_beat(CMD_PIN, 1'b0, 1'b0, 32'hFFFF_FFFF);
      push_beat(CMD_PIN, 1'b1, 1'b0, 32'h0);
      push_beat(CMD_PIN, 1'b1, 1'b1, 32'h0);
      push_beat(CMD_PIN, 1'b0, 1'b1, 32'h0);
      push_beat(CMD_PIN, 1'b0, 1'b0, 32'h0);
      push_beat(CMD_PIN, 1'b0, 1'b1, 32'h0);
      push_beat(CMD_PIN, 1'b1, 1'b1, 32'h0);
      push_beat(CMD_PIN, 1'b1, 1'b0, 32'h0);
      push_beat(CMD_PIN, 1'b0, 1'b0, 32'h0);
      push_beat(CMD_PIN, 1'b1, 1'b1, 32'h0);
      push_beat(CMD_PIN, 1'b1, 1'b1, 32'h5555_AAAA);
      push_beat(CMD_TICK, 1'b1, 1'b1, 32'hFFFF_FFFF);
      push_beat(CMD_NONE, 1'b0, 1'b1, 32'h1234_5678);
      push_beat(CMD_LOAD, 1'b0, 1'b0, 32'h7FFF_FFFF);
      push_beat(CMD_PIN, 1'b0, 1'b1, 32'h0);
      push_beat(CMD_TICK, 1'b0, 1'b0, 32'h0);
      push_beat(CMD_LOAD, 1'b1, 1'b1, 32'h8000_0000);
      push_beat(CMD_PIN, 1'b1, 1'b1, 32'h0);
      push_beat(CMD_TICK, 1'b0, 1'b0, 32'h0);
      push_beat(CMD_LOAD, 1'b0, 1'b0, 32'hFFFF_FFFF);
      push_beat(CMD_TICK, 1'b0, 1'b0, 32'h0);
      push_beat(CMD_LOAD, 1'b0, 1'b0, 32'h0);
      push_beat(CMD_TICK, 1'b0, 1'b0, 32'h0);
      push_beat(CMD_TICK, 1'b1, 1'b0, 32'h0);
      gen_pins = 2'b11;
      up       = 1'b1;

      // random: mostly clean step runs with ticks, some noise and loads
      repeat (RANDOM_BEATS) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(99) < 5) up = !up;
            if (up) begin
               case (gen_pins)
                  2'b00:   nxt = 2'b10;
                  2'b10:   nxt = 2'b11;
                  2'b11:   nxt = 2'b01;
                  default: nxt = 2'b00;
               endcase
            end else begin
               case (gen_pins)
                  2'b00:   nxt = 2'b01;
                  2'b01:   nxt = 2'b11;
                  2'b11:   nxt = 2'b10;
                  default: nxt = 2'b00;
               endcase
            end
            gen_pins = nxt;
            push_beat(CMD_PIN, gen_pins[1], gen_pins[0], $urandom);
         end else if (pick < 76) begin
            gen_pins = 2'($urandom_range(3));
            push_beat(CMD_PIN, gen_pins[1], gen_pins[0], $urandom);
         end else if (pick < 89) begin
            push_beat(CMD_TICK, 1'($urandom), 1'($urandom), $urandom);
         end else if (pick < 95) begin
            case ($urandom_range(3))
               0:       val = $urandom;
               1:       val = 32'h7FFF_FFFF;
               2:       val = 32'h8000_0000;
               default: val = 32'($urandom_range(200)) - 32'd100;
            endcase
            push_beat(CMD_LOAD, 1'($urandom), 1'($urandom), val);
         end else begin
            push_beat(CMD_NONE, 1'($urandom), 1'($urandom), $urandom);
         end
      end
      total_beats = pending_q.size();

      wait (beats_received >= total_beats);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d predicted response beats never arrived", expected_q.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
